// ----- rtl/pdsn_pkg.sv -----
// Package for the path dot-segment normalizer: opcodes, beat structs and
// character constants. No dependencies.
package pdsn_pkg;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_APPEND = 2'd1,
    OP_FINISH = 2'd2,
    OP_READ   = 2'd3
  } opcode_e;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] path_char;
    logic [7:0] read_index;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [8:0] path_length;
    logic       overflow;
  } out_beat_t;

endpackage

// ----- rtl/path_dot_segment_normalizer_unit.sv -----
// Top level of the path dot-segment normalizer: input register, segment
// update logic, character store, name-start stack and result register.
// Depends on pdsn_pkg.

// Takes one beat per clock unless in_stall_o is high and returns one result
// beat per input beat, through the input register and the result register.
// A start beat opens a path with the root slash, append beats carry the
// characters after it, a finish beat resolves the last segment and reports
// the canonical length, and read beats fetch stored characters by index.
// The rate is set by the single update path from the input register to the
// result register; the character store and the name-start stack each use
// one write and one registered read per cycle, and the top of the stack is
// held in a register so that ".." needs no read-back. No clearing pass
// after reset. path_length carries the low nine bits of the length.
module path_dot_segment_normalizer_unit #(
  parameter int PATH_DEPTH = 256,
  parameter int NAME_DEPTH = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pdsn_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pdsn_pkg::out_beat_t out_data_o
);
  import pdsn_pkg::*;

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int PW = $clog2(PATH_DEPTH + 1);
  localparam int NW = $clog2(NAME_DEPTH);
  localparam int CW = $clog2(NAME_DEPTH + 1);
  localparam int RW = (PW > 8) ? PW : 8;
  localparam int LW = (PW > 9) ? PW : 9;

  // input stage
  logic     s1_valid_q;
  in_beat_t s1_q;
  logic     out_valid_q;
  logic     adv;

  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  // path state
  logic [PW-1:0] fill_q, fill_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] seg_q, seg_d;
  logic          dots_q, dots_d;
  logic          ovf_q, ovf_d;
  logic [PW-1:0] fin_q, fin_d;
  logic [AW-1:0] top_q, top_d;
  logic [AW-1:0] next_q;

  logic          cw_en;
  logic [AW-1:0] cw_addr;
  logic [7:0]    cw_data;
  logic          sw_en;
  logic          rd_hit;
  logic [AW-1:0] rd_addr;
  logic [PW-1:0] len;
  logic [PW-1:0] fin_len;
  logic [PW-1:0] base;
  logic          full;
  logic [RW-1:0] ridx;
  logic [RW-1:0] rlen;
  logic [CW-1:0] nrd;

  assign full = (fill_q == PW'(PATH_DEPTH));
  assign base = fill_q - seg_q;
  assign ridx = RW'(s1_q.read_index);

  always_comb begin
    fin_len = fill_q;
    if (seg_q == '0) begin
      fin_len = fill_q;
    end else if (dots_q && seg_q == PW'(1)) begin
      fin_len = fill_q - PW'(1);
    end else if (dots_q && seg_q == PW'(2)) begin
      fin_len = (cnt_q != '0) ? PW'(top_q) : fill_q - PW'(2);
    end
    if (!(seg_q != '0 && !(dots_q && (seg_q == PW'(1) || seg_q == PW'(2))))) begin
      if (fin_len > PW'(1)) begin
        fin_len = fin_len - PW'(1);
      end
    end
  end

  always_comb begin
    fill_d  = fill_q;
    cnt_d   = cnt_q;
    seg_d   = seg_q;
    dots_d  = dots_q;
    ovf_d   = ovf_q;
    fin_d   = fin_q;
    top_d   = top_q;
    cw_en   = 1'b0;
    cw_addr = fill_q[AW-1:0];
    cw_data = s1_q.path_char;
    sw_en   = 1'b0;
    rd_hit  = 1'b0;
    rd_addr = ridx[AW-1:0];
    rlen    = '0;
    len     = fill_q;
    case (s1_q.opcode)
      OP_START: begin
        cw_en   = 1'b1;
        cw_addr = '0;
        cw_data = CH_SLASH;
        fill_d  = PW'(1);
        cnt_d   = '0;
        seg_d   = '0;
        dots_d  = 1'b1;
        ovf_d   = 1'b0;
        fin_d   = '0;
        len     = PW'(1);
      end
      OP_APPEND: begin
        fin_d = '0;
        if (s1_q.path_char == CH_SLASH) begin
          if (seg_q == '0) begin
            fill_d = fill_q;
          end else if (dots_q && seg_q == PW'(1)) begin
            fill_d = fill_q - PW'(1);
            seg_d  = '0;
            dots_d = 1'b1;
          end else if (dots_q && seg_q == PW'(2)) begin
            fill_d = fill_q - PW'(2);
            if (cnt_q != '0) begin
              cnt_d  = cnt_q - CW'(1);
              fill_d = PW'(top_q);
              top_d  = next_q;
            end
            seg_d  = '0;
            dots_d = 1'b1;
          end else if (full || cnt_q == CW'(NAME_DEPTH)) begin
            ovf_d = 1'b1;
          end else begin
            sw_en   = 1'b1;
            top_d   = base[AW-1:0];
            cnt_d   = cnt_q + CW'(1);
            cw_en   = 1'b1;
            cw_data = CH_SLASH;
            fill_d  = fill_q + PW'(1);
            seg_d   = '0;
            dots_d  = 1'b1;
          end
        end else if (full) begin
          ovf_d = 1'b1;
        end else begin
          cw_en  = 1'b1;
          fill_d = fill_q + PW'(1);
          seg_d  = seg_q + PW'(1);
          dots_d = dots_q && (s1_q.path_char == CH_DOT);
        end
        len = fill_d;
      end
      OP_FINISH: begin
        fin_d = fin_len;
        len   = fin_len;
      end
      OP_READ: begin
        len    = (fin_q != '0) ? fin_q : fill_q;
        rlen   = RW'(len);
        rd_hit = (ridx < rlen) && (ridx < RW'(PATH_DEPTH));
      end
      default: begin
        len = fill_q;
      end
    endcase
  end

  assign nrd = (adv ? cnt_d : cnt_q) - CW'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cnt_q  <= '0;
      seg_q  <= '0;
      dots_q <= 1'b1;
      ovf_q  <= 1'b0;
      fin_q  <= '0;
    end else if (adv) begin
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
      seg_q  <= seg_d;
      dots_q <= dots_d;
      ovf_q  <= ovf_d;
      fin_q  <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      top_q <= top_d;
    end
  end

  // character store
  logic [7:0] char_mem [PATH_DEPTH];
  logic [7:0] rdata_q;
  logic       hit_q;

  always_ff @(posedge clk_i) begin
    if (adv && cw_en) begin
      char_mem[cw_addr] <= cw_data;
    end
    if (adv && rd_hit) begin
      rdata_q <= char_mem[rd_addr];
    end
  end

  // name-start stack; next_q tracks the entry below the top
  logic [AW-1:0] name_mem [NAME_DEPTH];

  always_ff @(posedge clk_i) begin
    if (adv && sw_en) begin
      name_mem[cnt_q[NW-1:0]] <= base[AW-1:0];
    end
    next_q <= name_mem[nrd[NW-1:0]];
  end

  // result stage
  logic [LW-1:0] len_ext;
  logic [8:0]    len_q;
  logic          res_ovf_q;

  assign len_ext = LW'(len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      len_q     <= len_ext[8:0];
      res_ovf_q <= ovf_d;
      hit_q     <= rd_hit;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_data_o.out_char    = hit_q ? rdata_q : 8'h00;
  assign out_data_o.path_length = len_q;
  assign out_data_o.overflow    = res_ovf_q;

endmodule
